// ===== rtl/core/tgr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgr_pkg
// Shared types, constants and the arctangent table for the ring tagger.
// ----------------------------------------------------------------------------
package tgr_pkg;

    localparam int MAX_RINGS_DEF    = 128;
    localparam int MAX_POINTS_DEF   = 1048576;
    localparam int CORDIC_STEPS_DEF = 20;

    localparam int SQRT_STEPS     = 32;
    localparam int TIME_PROD_W    = 52;   // 32-bit period times 20-bit index
    localparam int TIME_QUO_W     = 32;
    localparam int RING_FIELD_MAX = 127;

    // +/- 90 degrees in Q12 millidegrees
    localparam logic signed [31:0] ELEV_90_Q12 = 32'sd368640000;

    // configuration register indexes
    localparam logic [2:0] CFG_MIN_ELEV  = 3'd0;
    localparam logic [2:0] CFG_MAX_ELEV  = 3'd1;
    localparam logic [2:0] CFG_RING_CNT  = 3'd2;
    localparam logic [2:0] CFG_DROP_OUT  = 3'd3;
    localparam logic [2:0] CFG_SCAN_PER  = 3'd4;

    // configuration reset values
    localparam logic signed [17:0] RST_MIN_ELEV = -18'sd25000;
    localparam logic signed [17:0] RST_MAX_ELEV = 18'sd15000;
    localparam logic [7:0]         RST_RING_CNT = 8'd32;
    localparam logic               RST_DROP_OUT = 1'b1;
    localparam logic [31:0]        RST_SCAN_PER = 32'd100000000;

    // per-point side data that rides along the whole pipe
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [15:0]        intensity;
        logic               finite;
        logic [31:0]        t;        // supplied time, later the final time
        logic               t_div;    // time comes from the divider
        logic               t_sat;    // synthesized time overflows 32 bits
        logic               s_zero;   // x and y both zero
        logic               drop;
        logic               r_zero;   // ring forced to 0
        logic               r_hi;     // ring clamped to the top ring
    } t_pass;

    typedef struct packed {
        logic [63:0]        s;
        logic [63:0]        res;
        logic signed [63:0] cy;
    } t_sqrt;

    typedef struct packed {
        logic signed [63:0] cx;
        logic signed [63:0] cy;
        logic signed [31:0] ang;
    } t_cord;

    // atan(2^-i) in Q12 millidegrees
    function automatic logic signed [31:0] atan_q12(input logic [4:0] idx);
        logic signed [31:0] v;
        case (idx)
            5'd0:  v = 32'sd184320000;
            5'd1:  v = 32'sd108810450;
            5'd2:  v = 32'sd57492453;
            5'd3:  v = 32'sd29184067;
            5'd4:  v = 32'sd14648666;
            5'd5:  v = 32'sd7331474;
            5'd6:  v = 32'sd3666632;
            5'd7:  v = 32'sd1833428;
            5'd8:  v = 32'sd916728;
            5'd9:  v = 32'sd458366;
            5'd10: v = 32'sd229183;
            5'd11: v = 32'sd114592;
            5'd12: v = 32'sd57296;
            5'd13: v = 32'sd28648;
            5'd14: v = 32'sd14324;
            5'd15: v = 32'sd7162;
            5'd16: v = 32'sd3581;
            5'd17: v = 32'sd1790;
            5'd18: v = 32'sd895;
            5'd19: v = 32'sd448;
            5'd20: v = 32'sd224;
            5'd21: v = 32'sd112;
            5'd22: v = 32'sd56;
            5'd23: v = 32'sd28;
            5'd24: v = 32'sd14;
            5'd25: v = 32'sd7;
            5'd26: v = 32'sd3;
            5'd27: v = 32'sd2;
            5'd28: v = 32'sd1;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/tgr_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgr interfaces
// Point input, tagged point output and configuration write channels.
// ----------------------------------------------------------------------------
interface tgr_pt_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               coords_finite;
    logic [15:0]        intensity;
    logic               has_time;
    logic [31:0]        time_in;
    logic [19:0]        point_index;
    logic [20:0]        point_count;

    modport source (output valid, pos_x, pos_y, pos_z, coords_finite, intensity,
                    has_time, time_in, point_index, point_count, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, coords_finite, intensity,
                    has_time, time_in, point_index, point_count, output ready);
endinterface

interface tgr_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [15:0]        out_intensity;
    logic [6:0]         ring;
    logic [31:0]        time_out;

    modport source (output valid, out_x, out_y, out_z, out_intensity, ring, time_out,
                    input ready);
    modport sink   (input valid, out_x, out_y, out_z, out_intensity, ring, time_out,
                    output ready);
endinterface

interface tgr_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/lidar_point_ring_tagger.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_point_ring_tagger
// Tags each lidar point with a ring number from its elevation and a time.
// ----------------------------------------------------------------------------
// Usage:
//   i_pt  : one point per transaction (valid/ready). Points with
//           coords_finite low, or outside a non-empty elevation window while
//           drop_outside is set, produce no output transaction.
//   o_pt  : tagged point: coordinates and intensity copied, ring, time.
//   i_cfg : register writes (index, data), always ready. Write only while
//           no point is in flight.
// Throughput is one point per clock while the receiver takes each output.
// The chain of cells, in order: 4 front stages, 32 square-root cells
// (the time divider runs alongside), CORDIC_STEPS rotation cells, 2 ring
// setup stages, clog2(MAX_RINGS) ring divider cells and the output register.
// The whole chain advances together: when the output register holds a
// transaction that the receiver does not take, every cell holds and i_pt
// ready goes low. Reset (synchronous, active low) empties the chain and
// loads the default window, ring count and scan period.
// ----------------------------------------------------------------------------
module lidar_point_ring_tagger #(
    parameter int MAX_RINGS    = tgr_pkg::MAX_RINGS_DEF,
    parameter int MAX_POINTS   = tgr_pkg::MAX_POINTS_DEF,
    parameter int CORDIC_STEPS = tgr_pkg::CORDIC_STEPS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tgr_pt_if.sink     i_pt,
    tgr_out_if.source  o_pt,
    tgr_cfg_if.sink    i_cfg
);
    localparam int NSQ  = tgr_pkg::SQRT_STEPS;
    localparam int NC   = CORDIC_STEPS;
    localparam int RQW  = $clog2(MAX_RINGS);
    localparam int PDW  = $clog2(MAX_POINTS);
    localparam int TQW  = tgr_pkg::TIME_QUO_W;
    localparam int TRW  = (PDW + TQW > tgr_pkg::TIME_PROD_W) ? PDW + TQW
                                                            : tgr_pkg::TIME_PROD_W;
    localparam int RRW  = 31 + RQW;
    localparam int NCW  = (RQW + 1 > 8) ? RQW + 1 : 8;
    localparam int CNW  = (PDW + 1 > 21) ? PDW + 1 : 21;
    localparam int RGW  = (RQW > 7) ? RQW : 7;

    localparam int S_B  = 1;
    localparam int S_C  = 2;
    localparam int S_D  = 3;
    localparam int S_CO = S_D + 1 + NSQ;
    localparam int S_G  = S_CO + NC;
    localparam int S_H  = S_G + 1;
    localparam int S_DV = S_H + 1;
    localparam int S_F  = S_DV + RQW;
    localparam int NST  = S_F + 1;

    // ---------------- configuration ----------------
    logic signed [17:0] r_min_elev;
    logic signed [17:0] r_max_elev;
    logic [7:0]         r_ring_cnt;
    logic               r_drop_out;
    logic [31:0]        r_scan_per;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_elev <= tgr_pkg::RST_MIN_ELEV;
            r_max_elev <= tgr_pkg::RST_MAX_ELEV;
            r_ring_cnt <= tgr_pkg::RST_RING_CNT;
            r_drop_out <= tgr_pkg::RST_DROP_OUT;
            r_scan_per <= tgr_pkg::RST_SCAN_PER;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                tgr_pkg::CFG_MIN_ELEV: r_min_elev <= i_cfg.data[17:0];
                tgr_pkg::CFG_MAX_ELEV: r_max_elev <= i_cfg.data[17:0];
                tgr_pkg::CFG_RING_CNT: r_ring_cnt <= i_cfg.data[7:0];
                tgr_pkg::CFG_DROP_OUT: r_drop_out <= i_cfg.data[0];
                tgr_pkg::CFG_SCAN_PER: r_scan_per <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // effective ring count minus one
    logic [NCW-1:0] w_n0;
    logic [NCW-1:0] w_neff;
    logic [RQW-1:0] w_nm1;

    assign w_n0   = (r_ring_cnt == 8'd0) ? NCW'(1) : NCW'(r_ring_cnt);
    assign w_neff = (w_n0 > NCW'(MAX_RINGS)) ? NCW'(MAX_RINGS) : w_n0;
    assign w_nm1  = RQW'(w_neff - NCW'(1));

    // ---------------- side data line ----------------
    tgr_pkg::t_pass r_pass [NST];
    tgr_pkg::t_pass n_pass [NST];

    // ---------------- chain control ----------------
    logic           w_en;
    logic [NST-1:0] r_vld;

    assign w_en       = !r_vld[NST-1] || o_pt.ready;
    assign i_pt.ready = w_en;

    // dropped points vanish on their way into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NST-2] && !r_pass[NST-2].drop, r_vld[NST-3:0], i_pt.valid};
        end
    end

    // ---------------- front stages ----------------
    logic [31:0]     w_ax;
    logic [31:0]     w_ay;
    logic [63:0]     r_sqx;
    logic [63:0]     r_sqy;
    logic [63:0]     r_s1;
    logic [63:0]     r_s2;
    logic [4:0]      r_k2;
    logic [4:0]      w_k;
    tgr_pkg::t_sqrt  r_sq0;
    tgr_pkg::t_sqrt  w_sq [NSQ+1];

    // time path front
    logic [CNW-1:0]  w_cnt;
    logic            w_cnt_ok;
    logic [PDW-1:0]  w_tdiv;
    logic [TRW-1:0]  r_tp0;
    logic [TRW-1:0]  r_tp1;
    logic [TRW-1:0]  r_tp2;
    logic [PDW-1:0]  r_td0;
    logic [PDW-1:0]  r_td1;
    logic [PDW-1:0]  r_td2;
    logic            w_tsat;
    logic [TRW-1:0]  w_trem [NSQ+1];
    logic [PDW-1:0]  w_tden [NSQ+1];
    logic [TQW-1:0]  w_tquo [NSQ+1];
    logic [TRW-1:0]  r_trem0;
    logic [PDW-1:0]  r_tden0;

    assign w_ax = i_pt.pos_x[31] ? 32'(-i_pt.pos_x) : i_pt.pos_x;
    assign w_ay = i_pt.pos_y[31] ? 32'(-i_pt.pos_y) : i_pt.pos_y;

    assign w_cnt    = (CNW'(i_pt.point_count) > CNW'(MAX_POINTS)) ? CNW'(MAX_POINTS)
                                                                  : CNW'(i_pt.point_count);
    assign w_cnt_ok = w_cnt > CNW'(1);
    assign w_tdiv   = PDW'(w_cnt - CNW'(1));
    assign w_tsat   = (TRW'(r_tp0 >> TQW) >= TRW'(r_td0));

    // normalize: shift pairs until the sum reaches 2^60, at most 16 times
    always_comb begin
        w_k = 5'd0;
        for (int j = 0; j < 16; j++) begin
            w_k = w_k + 5'(r_s1 < (64'(1) << (60 - 2 * j)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sqx     <= 64'(w_ax) * 64'(w_ax);
            r_sqy     <= 64'(w_ay) * 64'(w_ay);
            r_tp0     <= TRW'(r_scan_per) * TRW'(i_pt.point_index);
            r_td0     <= w_tdiv;
            r_s1      <= r_sqx + r_sqy;
            r_tp1     <= r_tp0;
            r_td1     <= r_td0;
            r_s2      <= r_s1;
            r_k2      <= w_k;
            r_tp2     <= r_tp1;
            r_td2     <= r_td1;
            r_sq0.s   <= r_s2 << {r_k2, 1'b0};
            r_sq0.res <= 64'd0;
            r_sq0.cy  <= 64'(r_pass[S_C].z) <<< r_k2;
            r_trem0   <= r_tp2;
            r_tden0   <= r_td2;
        end
    end

    // ---------------- square root and time divider cells ----------------
    assign w_sq[0]   = r_sq0;
    assign w_trem[0] = r_trem0;
    assign w_tden[0] = r_tden0;
    assign w_tquo[0] = '0;

    for (genvar i = 0; i < NSQ; i++) begin : g_sqrt
        tgr_sqrt_cell #(.IDX(i)) u_sqrt (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_d   (w_sq[i]),
            .o_q   (w_sq[i+1])
        );
        tgr_div_cell #(.RW(TRW), .DW(PDW), .QW(TQW), .SH(TQW - 1 - i)) u_tdiv (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_rem (w_trem[i]),
            .i_div (w_tden[i]),
            .i_quo (w_tquo[i]),
            .o_rem (w_trem[i+1]),
            .o_div (w_tden[i+1]),
            .o_quo (w_tquo[i+1])
        );
    end

    // ---------------- CORDIC cells ----------------
    tgr_pkg::t_cord w_co [NC+1];

    assign w_co[0].cx  = $signed(w_sq[NSQ].res);
    assign w_co[0].cy  = w_sq[NSQ].cy;
    assign w_co[0].ang = 32'sd0;

    for (genvar j = 0; j < NC; j++) begin : g_cordic
        tgr_cordic_cell #(.IDX(j)) u_cordic (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_d   (w_co[j]),
            .o_q   (w_co[j+1])
        );
    end

    // ---------------- ring setup ----------------
    logic signed [31:0] w_elev;
    logic signed [32:0] w_e33;
    logic signed [32:0] w_lo33;
    logic signed [32:0] w_hi33;
    logic               w_empty;
    logic               w_below;
    logic               w_above;
    logic [29:0]        r_num;
    logic [29:0]        r_den;
    tgr_pkg::t_pass     w_pg;

    assign w_pg    = r_pass[S_G-1];
    assign w_elev  = (w_pg.z == 32'sd0) ? 32'sd0 :
                     w_pg.s_zero ? (w_pg.z[31] ? -tgr_pkg::ELEV_90_Q12
                                               : tgr_pkg::ELEV_90_Q12) :
                     w_co[NC].ang;
    assign w_e33   = 33'(w_elev);
    assign w_lo33  = 33'(r_min_elev) <<< 12;
    assign w_hi33  = 33'(r_max_elev) <<< 12;
    assign w_empty = !(r_max_elev > r_min_elev);
    assign w_below = w_e33 < w_lo33;
    assign w_above = w_e33 > w_hi33;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_num <= (w_empty || w_below || w_above) ? 30'd0 : 30'(w_e33 - w_lo33);
            r_den <= w_empty ? 30'd1 : 30'(w_hi33 - w_lo33);
        end
    end

    // ---------------- ring divider ----------------
    logic [RRW-1:0] r_rrem0;
    logic [30:0]    r_rden0;
    logic [RRW-1:0] w_rrem [RQW+1];
    logic [30:0]    w_rden [RQW+1];
    logic [RQW-1:0] w_rquo [RQW+1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rrem0 <= ((RRW'(r_num) * RRW'(w_nm1)) << 1) + RRW'(r_den);
            r_rden0 <= {r_den, 1'b0};
        end
    end

    assign w_rrem[0] = r_rrem0;
    assign w_rden[0] = r_rden0;
    assign w_rquo[0] = '0;

    for (genvar m = 0; m < RQW; m++) begin : g_rdiv
        tgr_div_cell #(.RW(RRW), .DW(31), .QW(RQW), .SH(RQW - 1 - m)) u_rdiv (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_rem (w_rrem[m]),
            .i_div (w_rden[m]),
            .i_quo (w_rquo[m]),
            .o_rem (w_rrem[m+1]),
            .o_div (w_rden[m+1]),
            .o_quo (w_rquo[m+1])
        );
    end

    // ---------------- output stage ----------------
    logic [RQW-1:0] w_rsel;
    logic [RGW-1:0] w_rext;
    logic [6:0]     r_ring;

    assign w_rsel = r_pass[S_F-1].r_zero ? RQW'(0) :
                    r_pass[S_F-1].r_hi   ? w_nm1 : w_rquo[RQW];
    assign w_rext = RGW'(w_rsel);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ring <= (w_rext > RGW'(tgr_pkg::RING_FIELD_MAX))
                      ? 7'(tgr_pkg::RING_FIELD_MAX) : 7'(w_rext);
        end
    end

    // ---------------- side data updates ----------------
    always_comb begin
        n_pass[0].x         = i_pt.pos_x;
        n_pass[0].y         = i_pt.pos_y;
        n_pass[0].z         = i_pt.pos_z;
        n_pass[0].intensity = i_pt.intensity;
        n_pass[0].finite    = i_pt.coords_finite;
        n_pass[0].t         = i_pt.has_time ? i_pt.time_in : 32'd0;
        n_pass[0].t_div     = !i_pt.has_time && w_cnt_ok;
        n_pass[0].t_sat     = 1'b0;
        n_pass[0].s_zero    = 1'b0;
        n_pass[0].drop      = 1'b0;
        n_pass[0].r_zero    = 1'b0;
        n_pass[0].r_hi      = 1'b0;
        for (int k = 1; k < NST; k++) begin
            n_pass[k] = r_pass[k-1];
        end
        n_pass[S_B].t_sat  = w_tsat;
        n_pass[S_B].s_zero = (r_sqx + r_sqy) == 64'd0;
        if (r_pass[S_CO-1].t_div) begin
            n_pass[S_CO].t = r_pass[S_CO-1].t_sat ? 32'hFFFF_FFFF : w_tquo[NSQ];
        end
        n_pass[S_G].drop   = !w_pg.finite ||
                             (!w_empty && (w_below || w_above) && r_drop_out);
        n_pass[S_G].r_zero = w_empty || w_below;
        n_pass[S_G].r_hi   = !w_empty && w_above;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pass <= n_pass;
        end
    end

    assign o_pt.valid         = r_vld[NST-1];
    assign o_pt.out_x         = r_pass[NST-1].x;
    assign o_pt.out_y         = r_pass[NST-1].y;
    assign o_pt.out_z         = r_pass[NST-1].z;
    assign o_pt.out_intensity = r_pass[NST-1].intensity;
    assign o_pt.ring          = r_ring;
    assign o_pt.time_out      = r_pass[NST-1].t;

endmodule

// ===== rtl/core/tgr_sqrt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgr_sqrt_cell
// One bit of a restoring integer square root; z rides along.
// ----------------------------------------------------------------------------
module tgr_sqrt_cell #(
    parameter int IDX = 0
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  tgr_pkg::t_sqrt i_d,
    output tgr_pkg::t_sqrt o_q
);
    localparam int SHB = 62 - 2 * IDX;

    logic [63:0]    w_bit;
    logic [63:0]    w_trial;
    tgr_pkg::t_sqrt n_q;

    assign w_bit   = 64'(1) << SHB;
    assign w_trial = i_d.res + w_bit;

    always_comb begin
        n_q = i_d;
        if (i_d.s >= w_trial) begin
            n_q.s   = i_d.s - w_trial;
            n_q.res = (i_d.res >> 1) + w_bit;
        end else begin
            n_q.res = i_d.res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_q <= n_q;
        end
    end
endmodule

// ===== rtl/core/tgr_cordic_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgr_cordic_cell
// One vectoring CORDIC micro-rotation toward the x axis.
// ----------------------------------------------------------------------------
module tgr_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  tgr_pkg::t_cord i_d,
    output tgr_pkg::t_cord o_q
);
    logic signed [63:0] w_dx;
    logic signed [63:0] w_dy;
    tgr_pkg::t_cord     n_q;

    assign w_dx = i_d.cy >>> IDX;
    assign w_dy = i_d.cx >>> IDX;

    always_comb begin
        if (i_d.cy > 64'sd0) begin
            n_q.cx  = i_d.cx + w_dx;
            n_q.cy  = i_d.cy - w_dy;
            n_q.ang = i_d.ang + tgr_pkg::atan_q12(5'(IDX));
        end else begin
            n_q.cx  = i_d.cx - w_dx;
            n_q.cy  = i_d.cy + w_dy;
            n_q.ang = i_d.ang - tgr_pkg::atan_q12(5'(IDX));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_q <= n_q;
        end
    end
endmodule

// ===== rtl/core/tgr_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgr_div_cell
// One quotient bit of a restoring divider.
// ----------------------------------------------------------------------------
module tgr_div_cell #(
    parameter int RW = 40,
    parameter int DW = 31,
    parameter int QW = 8,
    parameter int SH = 0
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [RW-1:0] i_rem,
    input  logic [DW-1:0] i_div,
    input  logic [QW-1:0] i_quo,
    output logic [RW-1:0] o_rem,
    output logic [DW-1:0] o_div,
    output logic [QW-1:0] o_quo
);
    logic [RW-1:0] w_trial;
    logic          w_ge;

    assign w_trial = RW'(i_div) << SH;
    assign w_ge    = i_rem >= w_trial;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem <= w_ge ? i_rem - w_trial : i_rem;
            o_div <= i_div;
            o_quo <= w_ge ? (i_quo | (QW'(1) << SH)) : i_quo;
        end
    end
endmodule
